FILE: hdl/key_click_event_detector_defines.svh
// ----------------------------------------------------------------------------
// Key click event detector assertion macros
// Shared concurrent assertion forms for the detector's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef KEY_CLICK_EVENT_DETECTOR_DEFINES_SVH
`define KEY_CLICK_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCED_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key click detector check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KCED_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key click detector check failed");

`endif

FILE: hdl/kced_pkg.sv
// ----------------------------------------------------------------------------
// Key click event detector package
// Shared widths, mode and event codes, register indexes and state types.
// ----------------------------------------------------------------------------
package kced_pkg;

    localparam int NUM_KEYS = 3;
    localparam int KEY_W    = 2;
    localparam int TIME_W   = 16;
    localparam int MODE_W   = 3;
    localparam int EVENT_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Per-key modes.
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRESSED  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LTRIG    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LHOLD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAITREL  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RELEASED = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SHORT    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DOUBLE   = 3'd7;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_TIMEOUT  = 3'd4;

    // Configuration reset values in milliseconds.
    localparam logic [TIME_W-1:0] RST_LONG_PRESS  = 16'd1000;
    localparam logic [TIME_W-1:0] RST_REPEAT      = 16'd200;
    localparam logic [TIME_W-1:0] RST_DOUBLE_WIN  = 16'd300;
    localparam logic [TIME_W-1:0] RST_MIN_PRESS   = 16'd50;
    localparam logic [TIME_W-1:0] RST_REL_TIMEOUT = 16'd500;

    typedef struct packed {
        logic [TIME_W-1:0] long_press_time;
        logic [TIME_W-1:0] repeat_interval;
        logic [TIME_W-1:0] double_click_window;
        logic [TIME_W-1:0] min_press_time;
        logic [TIME_W-1:0] release_timeout;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] release_stamp;
        logic [TIME_W-1:0] last_repeat;
    } t_key_state;

    localparam t_key_state KEY_STATE_RESET = '{
        mode:          MODE_IDLE,
        press_start:   '0,
        release_stamp: '0,
        last_repeat:   '0
    };

endpackage

FILE: hdl/key_click_event_detector.sv
// ----------------------------------------------------------------------------
// Key click event detector
// Per-key press classifier: short, double and repeating long press events.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  input     i_valid / o_ready      i_key_index, i_key_level, i_now_ms
//  output    o_valid / i_ready      o_event_key, o_key_event
//  config    i_cfg_we (no wait)     i_cfg_idx, i_cfg_wdata
//
// One word is accepted per cycle while o_ready is high, and every accepted
// word yields exactly one result word. The word lands in the input register,
// then the key state machine updates that key's state and loads the result
// register as the word moves on. The state update reads and writes the key's
// state in the same cycle, so back-to-back words for the same key need no
// forwarding.
// Reset is synchronous and active low; it clears the mode and timestamps of
// every key and loads the default thresholds.
// A stalled output holds the result register; the input register keeps
// accepting until it too is full, so o_ready falls only when both are full.
//
// Samples for a key index beyond the key count leave all state untouched and
// return no event, with the sampled index echoed back.
// ----------------------------------------------------------------------------
`include "key_click_event_detector_defines.svh"

module key_click_event_detector
    import kced_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Poll sample input.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [KEY_W-1:0]     i_key_index,
    input  logic                 i_key_level,
    input  logic [TIME_W-1:0]    i_now_ms,
    // Event output.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [KEY_W-1:0]     o_event_key,
    output logic [EVENT_W-1:0]   o_key_event,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_wdata
);

    // Input register.
    logic                 r_in_vld;
    logic [KEY_W-1:0]     r_key;
    logic                 r_level;
    logic [TIME_W-1:0]    r_now;

    // Result register.
    logic                 r_out_vld;
    logic [KEY_W-1:0]     r_out_key;
    logic [EVENT_W-1:0]   r_out_event;

    // Per-key state, one entry per key.
    t_key_state           r_state [NUM_KEYS];

    t_cfg                 w_cfg;
    t_key_state           w_cur;
    t_key_state           w_next;
    logic [EVENT_W-1:0]   w_event;
    logic                 w_in_range;
    logic                 w_adv;
    logic                 w_out_free;

    kced_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // The result register can take a new word when it is empty or being read.
    assign w_out_free = !r_out_vld || i_ready;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_ready    = !r_in_vld || w_out_free;

    assign w_in_range = (32'(r_key) < NUM_KEYS);

    // Select the addressed key's state; an out-of-range key sees a reset state
    // whose outcome is discarded below.
    always_comb begin
        w_cur = KEY_STATE_RESET;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (32'(r_key) == k) begin
                w_cur = r_state[k];
            end
        end
    end

    kced_key_fsm u_fsm (
        .i_cur     (w_cur),
        .i_pressed (!r_level),
        .i_now     (r_now),
        .i_cfg     (w_cfg),
        .o_next    (w_next),
        .o_event   (w_event)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_key   <= i_key_index;
            r_level <= i_key_level;
            r_now   <= i_now_ms;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_key   <= r_key;
            r_out_event <= w_in_range ? w_event : EV_NONE;
        end
    end

    // Key state update, written back in the cycle the word moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_state[k] <= KEY_STATE_RESET;
            end
        end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (w_adv && (32'(r_key) == k)) begin
                    r_state[k] <= w_next;
                end
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_event_key = r_out_key;
    assign o_key_event = r_out_event;

    // An event can only be reported for a key that exists.
    `KCED_ASSERT_SAME(a_event_key_in_range, i_clk, i_rst_n,
        r_out_vld && (r_out_event != EV_NONE), 32'(r_out_key) < NUM_KEYS)

    // A key in the short report mode reports a short press when its word moves.
    `KCED_ASSERT_NEXT(a_short_reported, i_clk, i_rst_n,
        w_adv && w_in_range && (w_cur.mode == MODE_SHORT), r_out_event == EV_SHORT)

    // A held input word is never overwritten by a new acceptance.
    `KCED_ASSERT_SAME(a_input_held, i_clk, i_rst_n,
        r_in_vld && !w_adv, !o_ready)

endmodule

FILE: hdl/kced_cfg_regs.sv
// ----------------------------------------------------------------------------
// Key click event detector configuration registers
// Holds the five timing thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module kced_cfg_regs
    import kced_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [TIME_W-1:0]    i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_time     <= RST_LONG_PRESS;
            r_cfg.repeat_interval     <= RST_REPEAT;
            r_cfg.double_click_window <= RST_DOUBLE_WIN;
            r_cfg.min_press_time      <= RST_MIN_PRESS;
            r_cfg.release_timeout     <= RST_REL_TIMEOUT;
        end else if (i_we) begin
            // Writes to unused indexes are dropped.
            unique case (i_idx)
                CFG_LONG_PRESS:  r_cfg.long_press_time     <= i_wdata;
                CFG_REPEAT:      r_cfg.repeat_interval     <= i_wdata;
                CFG_DOUBLE_WIN:  r_cfg.double_click_window <= i_wdata;
                CFG_MIN_PRESS:   r_cfg.min_press_time      <= i_wdata;
                CFG_REL_TIMEOUT: r_cfg.release_timeout     <= i_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/kced_key_fsm.sv
// ----------------------------------------------------------------------------
// Key click event detector key state machine
// Next-state and event logic for one poll sample of one key.
// ----------------------------------------------------------------------------
module kced_key_fsm
    import kced_pkg::*;
(
    input  t_key_state           i_cur,
    input  logic                 i_pressed,
    input  logic [TIME_W-1:0]    i_now,
    input  t_cfg                 i_cfg,
    output t_key_state           o_next,
    output logic [EVENT_W-1:0]   o_event
);

    logic [TIME_W-1:0] w_d_press;
    logic [TIME_W-1:0] w_d_rel;
    logic [TIME_W-1:0] w_d_rep;
    logic [TIME_W-1:0] w_held;

    // All differences wrap at the timestamp width.
    assign w_d_press = i_now - i_cur.press_start;
    assign w_d_rel   = i_now - i_cur.release_stamp;
    assign w_d_rep   = i_now - i_cur.last_repeat;
    assign w_held    = i_cur.release_stamp - i_cur.press_start;

    always_comb begin
        o_next  = i_cur;
        o_event = EV_NONE;
        unique case (i_cur.mode)
            MODE_IDLE: begin
                if (i_pressed) begin
                    o_next.mode        = MODE_PRESSED;
                    o_next.press_start = i_now;
                    o_next.last_repeat = i_now;
                end
            end
            MODE_PRESSED: begin
                if (!i_pressed) begin
                    o_next.mode          = MODE_RELEASED;
                    o_next.release_stamp = i_now;
                end else if (w_d_press > i_cfg.long_press_time) begin
                    o_next.mode = MODE_LTRIG;
                end
            end
            MODE_LTRIG: begin
                if (i_pressed) begin
                    o_event            = EV_LONG;
                    o_next.mode        = MODE_LHOLD;
                    o_next.last_repeat = i_now;
                end else begin
                    o_next.mode = MODE_WAITREL;
                end
            end
            MODE_LHOLD: begin
                if (!i_pressed) begin
                    o_next.mode = MODE_WAITREL;
                end else if (w_d_rep >= i_cfg.repeat_interval) begin
                    o_event            = EV_LONG;
                    o_next.last_repeat = i_now;
                end
            end
            MODE_WAITREL: begin
                if (!i_pressed) begin
                    o_next.mode = MODE_IDLE;
                end
            end
            MODE_RELEASED: begin
                if (i_pressed && (w_d_rel < i_cfg.double_click_window)) begin
                    o_next.mode = MODE_DOUBLE;
                end else if ((w_held > i_cfg.min_press_time) &&
                             (w_d_rel > i_cfg.double_click_window)) begin
                    o_next.mode = MODE_SHORT;
                end else if (w_d_rel > i_cfg.release_timeout) begin
                    o_next.mode = MODE_IDLE;
                end
            end
            MODE_SHORT: begin
                o_event     = EV_SHORT;
                o_next.mode = MODE_WAITREL;
            end
            MODE_DOUBLE: begin
                o_event     = EV_DOUBLE;
                o_next.mode = MODE_WAITREL;
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

FILE: verif/key_click_event_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key click event detector testbench
// Streams per-key poll samples into the detector and checks every event word
// against a cycle-free model of the per-key press state machines. The run
// covers directed click, double click, long press and wrap cases, then
// several threshold settings with random click and hold sequences, noise and
// random idling on both channels.
// ----------------------------------------------------------------------------
module key_click_event_detector_test;
    import kced_pkg::*;

    // Pin levels of a key: the line is pulled low while the key is held.
    localparam logic LVL_DOWN = 1'b0;
    localparam logic LVL_UP   = 1'b1;

    // Random polls per threshold setting; seven settings give about 1450.
    localparam int PHASE_POLLS  = 207;
    localparam int NUM_PHASES   = 7;
    // Two register stages inside the block, with spare margin on top.
    localparam int DRAIN_CYCLES = 8;
    // Cycles for which the event side refuses words during the pressure test.
    localparam int HOLD_CYCLES  = 80;
    // Upper bound on the run time for about 1500 words, many times the worst
    // case.
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              level;
        logic [TIME_W-1:0] stamp;
    } t_poll;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [EVENT_W-1:0] code;
    } t_event_word;

    // Clock, reset and every block input start at known values.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [KEY_W-1:0]     i_key_index = '0;
    logic                 i_key_level = LVL_UP;
    logic [TIME_W-1:0]    i_now_ms    = '0;
    logic                 i_ready     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [TIME_W-1:0]    i_cfg_wdata = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic [KEY_W-1:0]     o_event_key;
    logic [EVENT_W-1:0]   o_key_event;

    key_click_event_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_key_index (i_key_index),
        .i_key_level (i_key_level),
        .i_now_ms    (i_now_ms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_event_key (o_event_key),
        .o_key_event (o_key_event),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Model state: thresholds as last written, and one tracker per key.
    t_cfg        thr_model;
    t_key_state  key_track [NUM_KEYS];

    t_poll       poll_queue[$];
    t_event_word expected_events[$];
    int          mismatch_count = 0;
    int          polls_made;

    // Sequence builder state: a private millisecond clock per key.
    logic [TIME_W-1:0] key_clock [NUM_KEYS];

    // Traffic shaping. The switches are written by the stimulus process with
    // nonblocking assignments so that the driver and monitor always see stable values.
    logic idle_on  = 1'b0;
    logic rx_block = 1'b0;
    int   tx_wait;
    int   rx_wait;

    // ------------------------------------------------------------------------
    // Event prediction.
    // Advances the tracker of the sampled key and returns the word that the
    // block must produce for this sample. All elapsed times are 16-bit
    // differences, so a stamp that looks to be in the future reads as a long
    // elapsed time. Samples for a key beyond the key count touch nothing.
    // ------------------------------------------------------------------------
    function automatic t_event_word classify_poll(input logic [KEY_W-1:0] k,
                                                  input logic lvl,
                                                  input logic [TIME_W-1:0] now);
        t_event_word       r;
        logic              down;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_repeat;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] held;
        r.key  = k;
        r.code = EV_NONE;
        down   = (lvl == LVL_DOWN);
        if (k < NUM_KEYS) begin
            since_press  = now - key_track[k].press_start;
            since_repeat = now - key_track[k].last_repeat;
            gap          = now - key_track[k].release_stamp;
            held         = key_track[k].release_stamp - key_track[k].press_start;
            case (key_track[k].mode)
                MODE_IDLE: begin
                    if (down) begin
                        key_track[k].mode        = MODE_PRESSED;
                        key_track[k].press_start = now;
                        key_track[k].last_repeat = now;
                    end
                end
                MODE_PRESSED: begin
                    if (!down) begin
                        key_track[k].release_stamp = now;
                        key_track[k].mode          = MODE_RELEASED;
                    end else if (since_press > thr_model.long_press_time) begin
                        key_track[k].mode = MODE_LTRIG;
                    end
                end
                MODE_LTRIG: begin
                    // The first long press event fires on the sample after
                    // the hold time has been crossed.
                    if (down) begin
                        r.code                   = EV_LONG;
                        key_track[k].mode        = MODE_LHOLD;
                        key_track[k].last_repeat = now;
                    end else begin
                        key_track[k].mode = MODE_WAITREL;
                    end
                end
                MODE_LHOLD: begin
                    if (!down) begin
                        key_track[k].mode = MODE_WAITREL;
                    end else if (since_repeat >= thr_model.repeat_interval) begin
                        r.code                   = EV_LONG;
                        key_track[k].last_repeat = now;
                    end
                end
                MODE_WAITREL: begin
                    if (!down) begin
                        key_track[k].mode = MODE_IDLE;
                    end
                end
                MODE_RELEASED: begin
                    // A second press inside the window wins over a short
                    // click; an unqualified click just times out to idle.
                    if (down && gap < thr_model.double_click_window) begin
                        key_track[k].mode = MODE_DOUBLE;
                    end else if (held > thr_model.min_press_time &&
                                 gap > thr_model.double_click_window) begin
                        key_track[k].mode = MODE_SHORT;
                    end else if (gap > thr_model.release_timeout) begin
                        key_track[k].mode = MODE_IDLE;
                    end
                end
                MODE_SHORT: begin
                    r.code            = EV_SHORT;
                    key_track[k].mode = MODE_WAITREL;
                end
                default: begin
                    r.code            = EV_DOUBLE;
                    key_track[k].mode = MODE_WAITREL;
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------------
    function automatic void queue_poll(input logic [KEY_W-1:0] k, input logic lvl,
                                       input logic [TIME_W-1:0] t);
        poll_queue.push_back('{k, lvl, t});
        polls_made++;
    endfunction

    // Queues one sample of a sequence and, now and then, a stray sample that
    // lands on any key, including the unused index.
    function automatic void seq_poll(input logic [KEY_W-1:0] k, input logic lvl,
                                     input logic [TIME_W-1:0] t);
        logic [KEY_W-1:0]  sk;
        logic [TIME_W-1:0] st;
        queue_poll(k, lvl, t);
        if ($urandom_range(0, 7) == 0) begin
            sk = KEY_W'($urandom_range(0, 3));
            if (sk < NUM_KEYS) begin
                st = key_clock[sk] + TIME_W'($urandom_range(0, 400));
            end else begin
                st = TIME_W'($urandom);
            end
            queue_poll(sk, 1'($urandom_range(0, 1)), st);
        end
    endfunction

    // A duration around a threshold: just under, on it, just over, or well
    // to either side. Values wrap, which is what the block must handle.
    function automatic logic [TIME_W-1:0] near(input logic [TIME_W-1:0] thr);
        case ($urandom_range(0, 5))
            0:       return thr - 1'b1;
            1:       return thr;
            2:       return thr + 1'b1;
            3:       return TIME_W'($urandom_range(0, thr));
            4:       return thr + TIME_W'($urandom_range(0, thr));
            default: return thr + TIME_W'($urandom_range(2, 20));
        endcase
    endfunction

    // Press, release, then either a second press or a run of released polls
    // around the double click window and the release timeout.
    function automatic void add_click(input logic [KEY_W-1:0] k);
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] tr;
        logic [TIME_W-1:0] t;
        int                n;
        t0 = key_clock[k];
        seq_poll(k, LVL_DOWN, t0);
        n = $urandom_range(0, 2);
        repeat (n) seq_poll(k, LVL_DOWN, t0 + TIME_W'($urandom_range(0,
                                                    thr_model.min_press_time)));
        tr = t0 + near(thr_model.min_press_time);
        seq_poll(k, LVL_UP, tr);
        t = tr;
        if ($urandom_range(0, 2) == 0) begin
            t = tr + near(thr_model.double_click_window);
            seq_poll(k, LVL_DOWN, t);
            seq_poll(k, 1'($urandom_range(0, 1)), t + TIME_W'($urandom_range(0, 50)));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                t = tr + near($urandom_range(0, 1) ? thr_model.double_click_window
                                                   : thr_model.release_timeout);
                seq_poll(k, ($urandom_range(0, 3) == 0) ? LVL_DOWN : LVL_UP, t);
            end
        end
        seq_poll(k, LVL_UP, t + 1'b1);
        seq_poll(k, LVL_UP, t + 2'd2);
        key_clock[k] = t + TIME_W'($urandom_range(3, 2000));
    endfunction

    // Press and hold across the long press time, then a train of polls
    // spaced around the repeat interval, then release.
    function automatic void add_hold(input logic [KEY_W-1:0] k);
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t;
        int                n;
        t0 = key_clock[k];
        t  = t0;
        seq_poll(k, LVL_DOWN, t0);
        n = $urandom_range(1, 3);
        repeat (n) begin
            t = t0 + near(thr_model.long_press_time);
            seq_poll(k, LVL_DOWN, t);
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
            t = t + near(thr_model.repeat_interval);
            seq_poll(k, LVL_DOWN, t);
        end
        t = t + TIME_W'($urandom_range(0, 30));
        seq_poll(k, LVL_UP, t);
        seq_poll(k, LVL_UP, t + 1'b1);
        key_clock[k] = t + TIME_W'($urandom_range(3, 2000));
    endfunction

    function automatic void add_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) queue_poll(KEY_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              TIME_W'($urandom));
    endfunction

    function automatic void fill_phase();
        logic [KEY_W-1:0] k;
        polls_made = 0;
        while (polls_made < PHASE_POLLS) begin
            k = KEY_W'($urandom_range(0, NUM_KEYS - 1));
            case ($urandom_range(0, 9))
                0:       add_noise();
                1, 2, 3: add_hold(k);
                default: add_click(k);
            endcase
        end
    endfunction

    function automatic logic [TIME_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return TIME_W'($urandom_range(1, 64));
            3:       return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(20, 1500));
        endcase
    endfunction

    // Writes all five thresholds, then the unused indexes with random data,
    // which the block must ignore. Only called while the block is idle.
    task automatic program_thresholds(input t_cfg c);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [TIME_W-1:0]    val [5];
        int                   i;
        idx = '{CFG_LONG_PRESS, CFG_REPEAT, CFG_DOUBLE_WIN, CFG_MIN_PRESS, CFG_REL_TIMEOUT};
        val = '{c.long_press_time, c.repeat_interval, c.double_click_window,
                c.min_press_time, c.release_timeout};
        for (i = 0; i < 5; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[i];
            i_cfg_wdata <= val[i];
        end
        for (i = CFG_REL_TIMEOUT + 1; i < (1 << CFG_IDX_W); i++) begin
            @(posedge i_clk);
            i_cfg_idx   <= CFG_IDX_W'(i);
            i_cfg_wdata <= TIME_W'($urandom);
        end
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        thr_model = c;
    endtask

    // Waits until every queued sample was taken and every event word came
    // back, then lets the pipeline settle. Polling happens on the falling
    // edge so that the driver's and monitor's updates are already visible.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (poll_queue.size() != 0 || i_valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Sample driver. A word is taken at an edge where i_valid and o_ready
    // are both high; its expected event is computed at that same edge, with
    // the thresholds in force. Between words the driver waits a per-word
    // random number of cycles when idling is enabled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : poll_driver
        t_poll p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_events.push_back(classify_poll(i_key_index, i_key_level,
                                                        i_now_ms));
            end
            if (!i_valid || o_ready) begin
                if (tx_wait == 0 && poll_queue.size() != 0) begin
                    p = poll_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_key_index <= p.key;
                    i_key_level <= p.level;
                    i_now_ms    <= p.stamp;
                    tx_wait     <= idle_on ? $urandom_range(0, 9) : 0;
                end else begin
                    i_valid <= 1'b0;
                    if (tx_wait != 0) begin
                        tx_wait <= tx_wait - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event monitor. Each accepted event word is checked against the oldest
    // prediction. After each word the receiver may refuse words for a random
    // number of cycles, and it refuses all words while rx_block is set.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : event_monitor
        int          w;
        t_event_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            w = rx_wait;
            if (o_valid && i_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: event word with none expected: key %0d event %0d",
                             $time, o_event_key, o_key_event);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_key !== want.key) begin
                        $display("%0t: event_key mismatch: expected %0d, actual %0d",
                                 $time, want.key, o_event_key);
                        mismatch_count++;
                    end
                    if (o_key_event !== want.code) begin
                        $display("%0t: key_event mismatch: expected %0d, actual %0d",
                                 $time, want.code, o_key_event);
                        mismatch_count++;
                    end
                end
                w = idle_on ? $urandom_range(0, 9) : 0;
            end else if (w != 0) begin
                w = w - 1;
            end
            rx_wait <= w;
            i_ready <= !rx_block && (w == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence: reset, directed cases at the reset thresholds, then
    // random traffic under several threshold settings.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_cfg c;
        int   ph;
        int   k;

        thr_model = '{RST_LONG_PRESS, RST_REPEAT, RST_DOUBLE_WIN, RST_MIN_PRESS,
                      RST_REL_TIMEOUT};
        for (k = 0; k < NUM_KEYS; k++) begin
            key_track[k] = KEY_STATE_RESET;
            key_clock[k] = TIME_W'($urandom);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset thresholds (hold 1000, repeat 200, window
        // 300, minimum press 50, timeout 500).
        // The unused key index at both levels and both stamp extremes.
        queue_poll(2'd3, LVL_DOWN, 16'hFFFF);
        queue_poll(2'd3, LVL_UP, 16'h0000);
        // Short click whose press straddles the timestamp wrap (held 64 ms),
        // reported once the gap passes the window, then released to idle.
        queue_poll(2'd0, LVL_DOWN, 16'hFFF0);
        queue_poll(2'd0, LVL_UP, 16'h0030);
        queue_poll(2'd0, LVL_UP, 16'h015D);
        queue_poll(2'd0, LVL_UP, 16'h0200);
        queue_poll(2'd0, LVL_UP, 16'h0210);
        // Double click: second press 299 ms after release.
        queue_poll(2'd1, LVL_DOWN, 16'd100);
        queue_poll(2'd1, LVL_UP, 16'd200);
        queue_poll(2'd1, LVL_DOWN, 16'd499);
        queue_poll(2'd1, LVL_DOWN, 16'd500);
        queue_poll(2'd1, LVL_UP, 16'd600);
        // Long press: exactly the hold time does not trigger, one more ms
        // does; then a repeat on the interval and none one ms short of it.
        queue_poll(2'd2, LVL_DOWN, 16'd0);
        queue_poll(2'd2, LVL_DOWN, 16'd1000);
        queue_poll(2'd2, LVL_DOWN, 16'd1001);
        queue_poll(2'd2, LVL_DOWN, 16'd1100);
        queue_poll(2'd2, LVL_DOWN, 16'd1300);
        queue_poll(2'd2, LVL_DOWN, 16'd1499);
        queue_poll(2'd2, LVL_UP, 16'd1500);
        queue_poll(2'd2, LVL_UP, 16'd1501);
        // A press of exactly the minimum time is no click; it times out
        // only once the gap exceeds the release timeout.
        queue_poll(2'd0, LVL_DOWN, 16'd1000);
        queue_poll(2'd0, LVL_UP, 16'd1050);
        queue_poll(2'd0, LVL_UP, 16'd1350);
        queue_poll(2'd0, LVL_UP, 16'd1551);
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;    // keep the reset thresholds
                1: program_thresholds('{'0, '0, '0, '0, '0});
                2: program_thresholds('{'1, '1, '1, '1, '1});
                default: begin
                    c.long_press_time     = pick_threshold();
                    c.repeat_interval     = pick_threshold();
                    c.double_click_window = pick_threshold();
                    c.min_press_time      = pick_threshold();
                    c.release_timeout     = pick_threshold();
                    program_thresholds(c);
                end
            endcase
            // Phases 0 and 4 run without any idling on either side.
            idle_on <= (ph != 0 && ph != 4);
            @(negedge i_clk);
            fill_phase();
            if (ph == 0) begin
                // Pressure: the event side refuses words for a long stretch
                // while samples keep coming, so both internal registers fill
                // and the block must drop o_ready.
                @(posedge i_clk);
                rx_block <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_block <= 1'b0;
            end
            wait_idle();
        end

        if (expected_events.size() != 0) begin
            $display("%0t: %0d expected event words never arrived",
                     $time, expected_events.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
